### hw/rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg - shared types and constants of the LRU tag cache lookup
// Key layout, widths and the text trimming function.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int unsigned ENTRIES_DEF = 96;
  localparam int unsigned TEXT_LO_W   = 64;
  localparam int unsigned TEXT_HI_W   = 56;
  localparam int unsigned SIZE_W      = 8;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned TEXT_BYTES  = (TEXT_LO_W + TEXT_HI_W) / 8;

  typedef struct packed {
    logic [TEXT_HI_W-1:0] text_high;
    logic [TEXT_LO_W-1:0] text_low;
    logic [SIZE_W-1:0]    key_size;
    logic [COLOR_W-1:0]   colour;
  } key_t;

  localparam int unsigned KEY_W = $bits(key_t);

  // Zero every text byte that follows the first zero byte.
  function automatic key_t trim_key(logic [TEXT_LO_W-1:0] lo,
                                    logic [TEXT_HI_W-1:0] hi,
                                    logic [SIZE_W-1:0]    sz,
                                    logic [COLOR_W-1:0]   col);
    logic [TEXT_LO_W+TEXT_HI_W-1:0] txt;
    logic                           live;
    key_t                           k;
    txt  = {hi, lo};
    live = 1'b1;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      if (!live) begin
        txt[i*8 +: 8] = 8'h00;
      end else if (txt[i*8 +: 8] == 8'h00) begin
        live = 1'b0;
      end
    end
    k.text_low  = txt[TEXT_LO_W-1:0];
    k.text_high = txt[TEXT_LO_W+TEXT_HI_W-1:TEXT_LO_W];
    k.key_size  = sz;
    k.colour    = col;
    return k;
  endfunction

endpackage

### hw/rtl/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram - single-port-write, single-port-read synchronous RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int unsigned WIDTH = ltc_pkg::KEY_W,
  parameter int unsigned DEPTH = ltc_pkg::ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lru_tag_cache_lookup.sv
// ----------------------------------------------------------------------------
// lru_tag_cache_lookup - fully associative tag store with LRU replacement
// Looks up a text/size/colour key, installs it on a miss, reports the slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one key word: text bytes
//   0..14, size and colour. Text bytes after the first zero byte are ignored.
//   Output channel (out_valid_o / out_ready_i) returns one word per key:
//   hit, slot and evicted.
//   One key is worked on at a time. Tags and use stamps live in two RAMs with
//   registered read data; the lookup reads one entry per cycle.
//   A key is first held against the filled entries in a tag scan. A hit, or a
//   miss while the store is not full, goes straight to the update step; a
//   miss in a full store first runs a victim scan over the stamp RAM. An
//   empty store skips the scan and installs into entry zero.
//   A finished result sits in the output register; the next key is accepted
//   while it waits. A stalled receiver holds the following result back in
//   the update step, so nothing is written until the word can be shown.
//   Reset empties the store (fill count and use tick to zero); no RAM sweep.
// ----------------------------------------------------------------------------
module lru_tag_cache_lookup #(
  parameter int unsigned ENTRIES = ltc_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ltc_pkg::TEXT_LO_W-1:0]       text_low_i,
  input  logic [ltc_pkg::TEXT_HI_W-1:0]       text_high_i,
  input  logic [ltc_pkg::SIZE_W-1:0]          key_size_i,
  input  logic [ltc_pkg::COLOR_W-1:0]         colour_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [ltc_pkg::SLOT_W-1:0]          slot_o,
  output logic                                evicted_o
);

  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned STAMP_W = ltc_pkg::STAMP_W;
  localparam int unsigned SLOT_W  = ltc_pkg::SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM,
    ST_UPDATE
  } state_e;

  state_e              state_q, state_d;
  ltc_pkg::key_t       key_q, key_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [STAMP_W-1:0]  best_stamp_q, best_stamp_d;
  logic [IDX_W-1:0]    tgt_q, tgt_d;
  logic                tgt_hit_q, tgt_hit_d;
  logic                tgt_evict_q, tgt_evict_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [STAMP_W-1:0]  tick_q, tick_d;
  logic                out_valid_q, out_valid_d;
  logic                hit_q, hit_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                evicted_q, evicted_d;

  // RAM side
  logic                tag_we, stamp_we;
  ltc_pkg::key_t       tag_rdata;
  logic [STAMP_W-1:0]  stamp_rdata;
  logic [STAMP_W-1:0]  stamp_wdata;

  logic                key_match, last_scan, store_full, last_entry, take;
  logic                out_free;
  logic [SLOT_W+IDX_W-1:0] slot_wide;

  ltc_ram #(
    .WIDTH (ltc_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tgt_q),
    .wdata_i (key_q),
    .raddr_i (idx_d),
    .rdata_o (tag_rdata)
  );

  ltc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (tgt_q),
    .wdata_i (stamp_wdata),
    .raddr_i (idx_d),
    .rdata_o (stamp_rdata)
  );

  // Read data in SCAN and VICTIM always belongs to idx_q: the RAMs are
  // addressed with idx_d, the next value of idx_q.
  assign key_match   = (tag_rdata == key_q);
  assign last_scan   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
  assign store_full  = (fill_q == CNT_W'(ENTRIES));
  assign last_entry  = (idx_q == IDX_W'(ENTRIES - 1));
  assign take        = (idx_q == '0) || (stamp_rdata < best_stamp_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign stamp_wdata = tick_q + STAMP_W'(1);
  assign slot_wide   = {{SLOT_W{1'b0}}, tgt_q};

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    idx_d        = idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    tgt_d        = tgt_q;
    tgt_hit_d    = tgt_hit_q;
    tgt_evict_d  = tgt_evict_q;
    fill_d       = fill_q;
    tick_d       = tick_q;
    out_valid_d  = out_valid_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    evicted_d    = evicted_q;
    tag_we       = 1'b0;
    stamp_we     = 1'b0;

    // Drop the shown word once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d = ltc_pkg::trim_key(text_low_i, text_high_i, key_size_i, colour_i);
          idx_d = '0;
          if (fill_q == '0) begin
            // Empty store: install straight into entry zero.
            tgt_d       = '0;
            tgt_hit_d   = 1'b0;
            tgt_evict_d = 1'b0;
            state_d     = ST_UPDATE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (key_match) begin
          tgt_d       = idx_q;
          tgt_hit_d   = 1'b1;
          tgt_evict_d = 1'b0;
          state_d     = ST_UPDATE;
        end else if (last_scan) begin
          if (store_full) begin
            idx_d   = '0;
            state_d = ST_VICTIM;
          end else begin
            tgt_d       = fill_q[IDX_W-1:0];
            tgt_hit_d   = 1'b0;
            tgt_evict_d = 1'b0;
            state_d     = ST_UPDATE;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_VICTIM: begin
        // Keep the oldest stamp; strict compare lets the lowest index win ties.
        if (take) begin
          best_idx_d   = idx_q;
          best_stamp_d = stamp_rdata;
        end
        if (last_entry) begin
          tgt_d       = take ? idx_q : best_idx_q;
          tgt_hit_d   = 1'b0;
          tgt_evict_d = 1'b1;
          state_d     = ST_UPDATE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_UPDATE: begin
        // Hold until the output register is free, then write back and show.
        if (out_free) begin
          tag_we      = !tgt_hit_q;
          stamp_we    = 1'b1;
          tick_d      = tick_q + STAMP_W'(1);
          if (!tgt_hit_q && !tgt_evict_q) begin
            fill_d = fill_q + CNT_W'(1);
          end
          out_valid_d = 1'b1;
          hit_d       = tgt_hit_q;
          slot_d      = slot_wide[SLOT_W-1:0];
          evicted_d   = tgt_evict_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_q        <= '0;
      idx_q        <= '0;
      best_idx_q   <= '0;
      best_stamp_q <= '0;
      tgt_q        <= '0;
      tgt_hit_q    <= 1'b0;
      tgt_evict_q  <= 1'b0;
      fill_q       <= '0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      evicted_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      key_q        <= key_d;
      idx_q        <= idx_d;
      best_idx_q   <= best_idx_d;
      best_stamp_q <= best_stamp_d;
      tgt_q        <= tgt_d;
      tgt_hit_q    <= tgt_hit_d;
      tgt_evict_q  <= tgt_evict_d;
      fill_q       <= fill_d;
      tick_q       <= tick_d;
      out_valid_q  <= out_valid_d;
      hit_q        <= hit_d;
      slot_q       <= slot_d;
      evicted_q    <= evicted_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;
  assign evicted_o   = evicted_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(ENTRIES))
    else $error("fill count beyond store depth");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported together with eviction");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> store_full)
    else $error("eviction while store not full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second key accepted while one is in flight");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE && out_free |=> tick_q == $past(tick_q) + STAMP_W'(1))
    else $error("use tick did not advance on update");
`endif

endmodule
